>>> hw/rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg: shared types and constants for the spring force block
// Controller states, datapath operation codes, command and status bundles.
// ----------------------------------------------------------------------------
package sfh_pkg;

    localparam int LEN_W     = 24;
    localparam int FORCE_W   = 32;
    localparam int STIFF_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 2'd1;

    localparam logic [LEN_W-1:0]   LEN_MAX     = 24'hFFFFFF;
    localparam logic [LEN_W-1:0]   REST_RESET  = 24'd256;
    localparam logic [STIFF_W-1:0] STIFF_RESET = 16'd256;
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAX = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_MULM,
        S_MULX,
        S_DIVX,
        S_MULY,
        S_DIVY,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_SQX,
        OP_SQY,
        OP_SQRT,
        OP_MULM,
        OP_MULX,
        OP_MULY,
        OP_DIVX,
        OP_DIVY
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic load_in;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic len_zero;
    } status_t;

endpackage

>>> hw/rtl/sfh_if.sv
// ----------------------------------------------------------------------------
// sfh_in_if / sfh_out_if: valid/ready channels of the spring force block
// Input word carries two endpoints, output word the forces and lengths.
// ----------------------------------------------------------------------------
interface sfh_in_if #(parameter int POS_WIDTH = 24);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] first_x;
    logic signed [POS_WIDTH-1:0] first_y;
    logic signed [POS_WIDTH-1:0] second_x;
    logic signed [POS_WIDTH-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface sfh_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_second_x;
    logic signed [31:0] force_second_y;
    logic signed [31:0] force_first_x;
    logic signed [31:0] force_first_y;
    logic        [23:0] current_length;
    logic        [23:0] shortest_seen;
    logic        [23:0] longest_seen;

    modport source (output valid, force_second_x, force_second_y, force_first_x,
                    force_first_y, current_length, shortest_seen, longest_seen,
                    input ready);
    modport sink   (input valid, force_second_x, force_second_y, force_first_x,
                    force_first_y, current_length, shortest_seen, longest_seen,
                    output ready);
endinterface

>>> hw/rtl/sfh_ctrl.sv
// ----------------------------------------------------------------------------
// sfh_ctrl: sequencer of the spring force block
// Steps the datapath through squares, root, multiplies and divides.
// ----------------------------------------------------------------------------
module sfh_ctrl
    import sfh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = OP_SQX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_SQX;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQY;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (status.done)
                begin
                    if (status.len_zero)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = OP_MULM;
                        state_next = S_MULM;
                    end
                end
            end
            S_MULM:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MULX;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIVX;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MULY;
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                if (status.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIVY;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (status.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/sfh_datapath.sv
// ----------------------------------------------------------------------------
// sfh_datapath: arithmetic of the spring force block
// Serial shift-add multiplier, digit-by-digit root, restoring divider.
// ----------------------------------------------------------------------------
module sfh_datapath
    import sfh_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_idx,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic signed [POS_WIDTH-1:0] first_x,
    input  logic signed [POS_WIDTH-1:0] first_y,
    input  logic signed [POS_WIDTH-1:0] second_x,
    input  logic signed [POS_WIDTH-1:0] second_y,
    output logic signed [FORCE_W-1:0]   force_second_x,
    output logic signed [FORCE_W-1:0]   force_second_y,
    output logic signed [FORCE_W-1:0]   force_first_x,
    output logic signed [FORCE_W-1:0]   force_first_y,
    output logic [LEN_W-1:0]            current_length,
    output logic [LEN_W-1:0]            shortest_seen,
    output logic [LEN_W-1:0]            longest_seen
);

    localparam int LW = POS_WIDTH + 1;              // difference and root width
    localparam int EW = (LW > LEN_W) ? LW : LEN_W;  // extension / multiplier b
    localparam int AW = STIFF_W + EW;               // multiplier a, m width
    localparam int PW = AW + EW;                    // product / quotient width
    localparam int SW = 2 * LW;                     // sum of squares
    localparam int RW = LW + 2;                     // root remainder
    localparam int DW = LW + 9;                     // divider remainder
    localparam int CW = $clog2(PW + 1);

    // control and configuration
    logic [STIFF_W-1:0] stiff_reg;
    logic [LEN_W-1:0]   rest_reg, short_reg, long_reg;
    op_t                op_reg;
    logic               busy_reg, done_reg;
    logic [CW-1:0]      cnt_reg;

    // payload
    logic signed [LW-1:0]    dx_reg, dy_reg;
    logic [LW-1:0]           len_reg, root_reg;
    logic [SW-1:0]           sum_reg, rad_reg;
    logic [AW-1:0]           m_reg;
    logic [PW-1:0]           ashift_reg, acc_reg, num_reg, q_reg;
    logic [EW-1:0]           b_reg;
    logic [RW-1:0]           srem_reg;
    logic [DW-1:0]           drem_reg;
    logic signed [FORCE_W-1:0] fx_reg, fy_reg;
    logic signed [FORCE_W-1:0] ofsx_reg, ofsy_reg, ofx_reg, ofy_reg;
    logic [LEN_W-1:0]        ocur_reg, oshort_reg, olong_reg;

    logic [LW-1:0]     ax, ay;
    logic [EW-1:0]     len_ext, rest_ext, ae;
    logic              eneg;
    logic [AW-1:0]     mul_a;
    logic [EW-1:0]     mul_b;
    logic [PW-1:0]     acc_step;
    logic [RW+1:0]     stmp, strial;
    logic              sge;
    logic [RW-1:0]     srem_n;
    logic [LW-1:0]     root_n;
    logic [DW-1:0]     dtmp, dvsr;
    logic              dge;
    logic [DW-1:0]     drem_n;
    logic [PW-1:0]     q_n;
    logic              q_big, dneg;
    logic [FORCE_W-1:0] q_sat;
    logic [CW-1:0]     last_cnt;
    logic              last;
    logic [LEN_W-1:0]  cur, short_upd, long_upd;

    assign ax = dx_reg[LW-1] ? LW'(-dx_reg) : LW'(dx_reg);
    assign ay = dy_reg[LW-1] ? LW'(-dy_reg) : LW'(dy_reg);

    assign len_ext  = EW'(len_reg);
    assign rest_ext = EW'(rest_reg);
    assign eneg     = len_ext < rest_ext;
    assign ae       = eneg ? (rest_ext - len_ext) : (len_ext - rest_ext);

    always_comb
    begin
        unique case (cmd.op)
            OP_SQX:
            begin
                mul_a = AW'(ax);
                mul_b = EW'(ax);
            end
            OP_SQY:
            begin
                mul_a = AW'(ay);
                mul_b = EW'(ay);
            end
            OP_MULM:
            begin
                mul_a = AW'(stiff_reg);
                mul_b = ae;
            end
            OP_MULX:
            begin
                mul_a = m_reg;
                mul_b = EW'(ax);
            end
            OP_MULY:
            begin
                mul_a = m_reg;
                mul_b = EW'(ay);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // multiplier step
    assign acc_step = b_reg[0] ? (acc_reg + ashift_reg) : acc_reg;

    // root step: bring down two radicand bits, try 4r+1
    assign stmp   = {srem_reg, rad_reg[SW-1 -: 2]};
    assign strial = (RW+2)'({root_reg, 2'b01});
    assign sge    = stmp >= strial;
    assign srem_n = sge ? RW'(stmp - strial) : RW'(stmp);
    assign root_n = {root_reg[LW-2:0], sge};

    // divider step, divisor is length with 8 fraction bits moved up
    assign dtmp   = {drem_reg[DW-2:0], num_reg[PW-1]};
    assign dvsr   = DW'({len_reg, 8'd0});
    assign dge    = dtmp >= dvsr;
    assign drem_n = dge ? (dtmp - dvsr) : dtmp;
    assign q_n    = {q_reg[PW-2:0], dge};

    assign q_big = (|q_n[PW-1:FORCE_W-1]);
    assign dneg  = eneg ^ ((op_reg == OP_DIVX) ? dx_reg[LW-1] : dy_reg[LW-1]);

    always_comb
    begin
        if (dneg)
        begin
            q_sat = q_big ? FORCE_NEG_MAX : (~q_n[FORCE_W-1:0] + 1'b1);
        end
        else
        begin
            q_sat = q_big ? FORCE_POS_MAX : q_n[FORCE_W-1:0];
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_SQRT:             last_cnt = CW'(LW - 1);
            OP_DIVX, OP_DIVY:    last_cnt = CW'(PW - 1);
            default:             last_cnt = CW'(EW - 1);
        endcase
    end
    assign last = (cnt_reg == last_cnt);

    assign cur       = (len_ext > EW'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_reg);
    assign short_upd = (cur < short_reg) ? cur : short_reg;
    assign long_upd  = (cur > long_reg) ? cur : long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
            rest_reg  <= REST_RESET;
            short_reg <= REST_RESET;
            long_reg  <= REST_RESET;
            op_reg    <= OP_SQX;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we && (cfg_idx == REG_STIFFNESS))
            begin
                stiff_reg <= cfg_data[STIFF_W-1:0];
            end
            priority if (cfg_we && (cfg_idx == REG_REST_LENGTH))
            begin
                rest_reg  <= cfg_data[LEN_W-1:0];
                short_reg <= cfg_data[LEN_W-1:0];
                long_reg  <= cfg_data[LEN_W-1:0];
            end
            else if (cmd.load_out)
            begin
                short_reg <= short_upd;
                long_reg  <= long_upd;
            end
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dx_reg <= LW'({second_x[POS_WIDTH-1], second_x})
                    - LW'({first_x[POS_WIDTH-1], first_x});
            dy_reg <= LW'({second_y[POS_WIDTH-1], second_y})
                    - LW'({first_y[POS_WIDTH-1], first_y});
            fx_reg <= '0;
            fy_reg <= '0;
        end
        if (cmd.start)
        begin
            unique case (cmd.op)
                OP_SQRT:
                begin
                    rad_reg  <= sum_reg;
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                OP_DIVX, OP_DIVY:
                begin
                    num_reg  <= acc_reg;
                    drem_reg <= '0;
                    q_reg    <= '0;
                end
                default:
                begin
                    ashift_reg <= PW'(mul_a);
                    b_reg      <= mul_b;
                    acc_reg    <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_SQRT:
                begin
                    rad_reg  <= rad_reg << 2;
                    srem_reg <= srem_n;
                    root_reg <= root_n;
                    if (last)
                    begin
                        len_reg <= root_n;
                    end
                end
                OP_DIVX, OP_DIVY:
                begin
                    num_reg  <= num_reg << 1;
                    drem_reg <= drem_n;
                    q_reg    <= q_n;
                    if (last)
                    begin
                        if (op_reg == OP_DIVX)
                        begin
                            fx_reg <= q_sat;
                        end
                        else
                        begin
                            fy_reg <= q_sat;
                        end
                    end
                end
                default:
                begin
                    acc_reg    <= acc_step;
                    ashift_reg <= ashift_reg << 1;
                    b_reg      <= b_reg >> 1;
                    if (last)
                    begin
                        if (op_reg == OP_SQX)
                        begin
                            sum_reg <= SW'(acc_step);
                        end
                        else if (op_reg == OP_SQY)
                        begin
                            sum_reg <= sum_reg + SW'(acc_step);
                        end
                        else if (op_reg == OP_MULM)
                        begin
                            m_reg <= AW'(acc_step);
                        end
                    end
                end
            endcase
        end
        if (cmd.load_out)
        begin
            ofsx_reg   <= fx_reg;
            ofsy_reg   <= fy_reg;
            ofx_reg    <= (fx_reg == FORCE_NEG_MAX) ? FORCE_POS_MAX : -fx_reg;
            ofy_reg    <= (fy_reg == FORCE_NEG_MAX) ? FORCE_POS_MAX : -fy_reg;
            ocur_reg   <= cur;
            oshort_reg <= short_upd;
            olong_reg  <= long_upd;
        end
    end

    assign status.done     = done_reg;
    assign status.len_zero = (len_reg == '0);

    assign force_second_x = ofsx_reg;
    assign force_second_y = ofsy_reg;
    assign force_first_x  = ofx_reg;
    assign force_first_y  = ofy_reg;
    assign current_length = ocur_reg;
    assign shortest_seen  = oshort_reg;
    assign longest_seen   = olong_reg;

endmodule

>>> hw/rtl/spring_force_hooke.sv
// ----------------------------------------------------------------------------
// spring_force_hooke: 2D Hooke spring force with length trackers
// Arithmetic: bit-serial multiplier, root and divider, one bit a cycle; a
//   zero length skips the multiply and divide steps.
// Flow: one word at a time; the next input is taken while a result waits.
// Reset: stiffness and rest length to 1.0, both trackers to the rest length.
// ----------------------------------------------------------------------------
module spring_force_hooke
    import sfh_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    sfh_in_if.sink               in_ch,
    sfh_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    // controller to datapath
    cmd_t    cmd;
    status_t status;

    // Sequencer: squares of dx and dy, root of the sum, stiffness times
    // extension, then per axis multiply by |d| and divide by length.
    sfh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath also holds the config registers and the output word register;
    // a zero length skips the force steps and leaves both forces at zero.
    sfh_datapath #(
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .first_x        (in_ch.first_x),
        .first_y        (in_ch.first_y),
        .second_x       (in_ch.second_x),
        .second_y       (in_ch.second_y),
        .force_second_x (out_ch.force_second_x),
        .force_second_y (out_ch.force_second_y),
        .force_first_x  (out_ch.force_first_x),
        .force_first_y  (out_ch.force_first_y),
        .current_length (out_ch.current_length),
        .shortest_seen  (out_ch.shortest_seen),
        .longest_seen   (out_ch.longest_seen)
    );

    // trackers always bracket the length they report with
    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.shortest_seen <= out_ch.current_length)
                      && (out_ch.current_length <= out_ch.longest_seen))
        else $error("length outside tracker range");

    // zero length gives zero force
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.current_length == '0))
            |-> (out_ch.force_second_x == '0) && (out_ch.force_second_y == '0))
        else $error("nonzero force at zero length");

    // first endpoint x force mirrors the second
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.force_first_x == -out_ch.force_second_x)
                      || (out_ch.force_second_x == FORCE_NEG_MAX))
        else $error("first force is not the negated second force");

    // ready is never high while the datapath signals done
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !status.done)
        else $error("ready while datapath busy");

endmodule

>>> tb/tb_spring_force_hooke.sv
// ----------------------------------------------------------------------------
// tb_spring_force_hooke: self-checking bench for the 2D Hooke spring block
// Drives endpoint words with random gaps, stalls the result side, predicts
// forces, length and trackers in a scoreboard class and compares every field.
// ----------------------------------------------------------------------------
module tb_spring_force_hooke;
    import sfh_pkg::*;

    localparam int PW          = 24;
    localparam int WATCH_LIMIT = 20000;   // > latency + longest stall, many times
    localparam int SETTLE      = 400;     // longer than one full word of latency

    // indexes past the last register, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        logic signed [31:0] fsx;
        logic signed [31:0] fsy;
        logic signed [31:0] ffx;
        logic signed [31:0] ffy;
        logic [23:0]        cur;
        logic [23:0]        shortest;
        logic [23:0]        longest;
    } spring_res_t;

    // Scoreboard: its own copy of the configuration and trackers.
    class spring_scoreboard;
        logic [15:0]  k;
        logic [23:0]  rest;
        logic [23:0]  lo_len;
        logic [23:0]  hi_len;
        spring_res_t  pending[$];
        int           errors;
        int           checked;

        function new();
            k = STIFF_RESET;
            rest = REST_RESET;
            lo_len = REST_RESET;
            hi_len = REST_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_STIFFNESS)
                k = v[15:0];
            else if (idx == REG_REST_LENGTH)
            begin
                rest = v;
                lo_len = v;
                hi_len = v;
            end
        endfunction

        // One force component: magnitude floor(m*|d|/(L*256)), signed, saturated.
        function logic signed [31:0] comp(logic [47:0] m, bit eneg,
                                          logic signed [33:0] d, logic [63:0] len);
            logic [33:0]  ad;
            logic [127:0] q;
            bit           neg;
            ad = d < 0 ? -d : d;
            q = ({80'd0, m} * {94'd0, ad}) / ({64'd0, len} << 8);
            neg = eneg ^ (d < 0);
            if (neg)
                return q >= 128'h8000_0000 ? FORCE_NEG_MAX : -$signed(q[31:0]);
            return q > 128'h7FFF_FFFF ? FORCE_POS_MAX : q[31:0];
        endfunction

        function void note_word(logic signed [PW-1:0] ax, ay, bx, by);
            logic signed [33:0] dx, dy;
            logic [67:0]        sq;
            logic [63:0]        len, c, ae;
            logic [47:0]        m;
            spring_res_t        r;
            bit                 eneg;
            dx = 34'(bx) - 34'(ax);
            dy = 34'(by) - 34'(ay);
            sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
            len = 0;
            for (int b = 33; b >= 0; b--)
            begin
                c = len | (64'd1 << b);
                if (68'(c) * 68'(c) <= sq)
                    len = c;
            end
            r.cur = len > LEN_MAX ? LEN_MAX : len[23:0];
            if (r.cur > hi_len) hi_len = r.cur;
            if (r.cur < lo_len) lo_len = r.cur;
            r.shortest = lo_len;
            r.longest = hi_len;
            r.fsx = 0;
            r.fsy = 0;
            if (len != 0)
            begin
                eneg = len < rest;
                ae = eneg ? rest - len : len - rest;
                m = 48'(k) * 48'(ae);
                r.fsx = comp(m, eneg, dx, len);
                r.fsy = comp(m, eneg, dy, len);
            end
            r.ffx = r.fsx == FORCE_NEG_MAX ? FORCE_POS_MAX : -r.fsx;
            r.ffy = r.fsy == FORCE_NEG_MAX ? FORCE_POS_MAX : -r.fsy;
            pending.push_back(r);
        endfunction

        function void check_word(spring_res_t a);
            spring_res_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.fsx !== e.fsx)
            begin
                errors++;
                $error("force_second_x exp %0d got %0d", e.fsx, a.fsx);
            end
            if (a.fsy !== e.fsy)
            begin
                errors++;
                $error("force_second_y exp %0d got %0d", e.fsy, a.fsy);
            end
            if (a.ffx !== e.ffx)
            begin
                errors++;
                $error("force_first_x exp %0d got %0d", e.ffx, a.ffx);
            end
            if (a.ffy !== e.ffy)
            begin
                errors++;
                $error("force_first_y exp %0d got %0d", e.ffy, a.ffy);
            end
            if (a.cur !== e.cur)
            begin
                errors++;
                $error("current_length exp %0d got %0d", e.cur, a.cur);
            end
            if (a.shortest !== e.shortest)
            begin
                errors++;
                $error("shortest_seen exp %0d got %0d", e.shortest, a.shortest);
            end
            if (a.longest !== e.longest)
            begin
                errors++;
                $error("longest_seen exp %0d got %0d", e.longest, a.longest);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    sfh_in_if #(.POS_WIDTH(PW)) in_ch();
    sfh_out_if out_ch();

    spring_force_hooke #(.POS_WIDTH(PW)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    spring_scoreboard sb = new();
    bit quiet;        // last part of the run: no gaps, no stalls
    int idle_cycles;
    int words_sent;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall bursts, check on every accepted word.
    initial
    begin
        int burst;
        spring_res_t r;
        out_ch.ready = 0;
        burst = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                r.fsx = out_ch.force_second_x;
                r.fsy = out_ch.force_second_y;
                r.ffx = out_ch.force_first_x;
                r.ffy = out_ch.force_first_y;
                r.cur = out_ch.current_length;
                r.shortest = out_ch.shortest_seen;
                r.longest = out_ch.longest_seen;
                sb.check_word(r);
            end
            if (burst > 0)
                burst--;
            else if (!quiet && $urandom_range(0, 3) == 0)
                burst = $urandom_range(1, 16);
            out_ch.ready <= (burst == 0);
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCH_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Valid drops after each word; the block is busy then anyway.
    task automatic send_word(logic signed [PW-1:0] ax, ay, bx, by);
        if (!quiet && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 16)) @(posedge clk);
        in_ch.valid <= 1;
        in_ch.first_x <= ax;
        in_ch.first_y <= ay;
        in_ch.second_x <= bx;
        in_ch.second_y <= by;
        @(posedge clk iff in_ch.ready);
        sb.note_word(ax, ay, bx, by);
        words_sent++;
        in_ch.valid <= 0;
        @(posedge clk);
    endtask

    // Only between phases: wait for all results, then the block's tail.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    // Random word: mostly small moves near a random base, some full range.
    task automatic random_word();
        logic signed [PW-1:0] ax, ay;
        int span;
        ax = PW'($urandom);
        ay = PW'($urandom);
        if ($urandom_range(0, 3) == 0)
            send_word(ax, ay, PW'($urandom), PW'($urandom));
        else
        begin
            span = 1 << $urandom_range(0, 16);
            send_word(ax, ay, PW'(ax + $signed($urandom_range(0, 2 * span)) - span),
                      PW'(ay + $signed($urandom_range(0, 2 * span)) - span));
        end
    endtask

    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = REG_STIFFNESS;
        cfg_data = 0;
        in_ch.valid = 0;
        in_ch.first_x = 0;
        in_ch.first_y = 0;
        in_ch.second_x = 0;
        in_ch.second_y = 0;
        quiet = 0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset config, coincident endpoints (zero length) first.
        send_word(0, 0, 0, 0);
        send_word(100, -50, 100, -50);
        send_word(0, 0, 256, 0);          // exactly rest length
        send_word(0, 0, 0, -512);
        send_word(0, 0, 3 * 256, 4 * 256);
        // Opposite corners: length saturates, force uses the full length.
        send_word(PMIN, PMIN, PMAX, PMAX);
        send_word(PMAX, PMAX, PMIN, PMIN);
        send_word(PMAX, 0, PMIN, 0);
        send_word(0, PMIN, 0, PMAX);
        // Stiff spring: force saturates both ways, incl. the negative minimum.
        write_reg(REG_STIFFNESS, 24'hFFFF);
        write_reg(REG_REST_LENGTH, 24'd0);
        send_word(PMIN, 0, PMAX, 0);
        send_word(PMAX, 0, PMIN, 0);
        send_word(0, PMIN, 0, PMAX);
        send_word(1, 1, 2, 1);
        write_reg(REG_REST_LENGTH, LEN_MAX);
        send_word(0, 0, 1, 0);
        send_word(5, 0, 0, 0);
        send_word(0, 0, 0, 0);
        send_word(PMIN, PMIN, PMAX, PMAX);
        write_reg(REG_STIFFNESS, 24'd0);
        send_word(0, 0, 1000, -1000);
        // Writes past the last register must be ignored.
        write_reg(REG_SPARE_LO, 24'h123456);
        write_reg(REG_SPARE_HI, LEN_MAX);
        send_word(0, 0, 1000, -1000);

        // Random phases, each with its own configuration.
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_STIFFNESS,
                      CFG_W'(ph == 0 ? 24'd1 : $urandom_range(0, 65535)));
            write_reg(REG_REST_LENGTH, CFG_W'(ph == 1 ? 24'd0 :
                      ($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom)));
            if (ph == 6)
                quiet = 1;
            repeat (100) random_word();
        end

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d endpoint words: corner cases, saturation, ignored writes",
                 words_sent);
        $display("and 7 random stiffness/rest settings; %0d results checked.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/sfh_pkg.sv
hw/rtl/sfh_if.sv
hw/rtl/sfh_ctrl.sv
hw/rtl/sfh_datapath.sv
hw/rtl/spring_force_hooke.sv
tb/tb_spring_force_hooke.sv
